FILE: sv/irts_pkg.sv
// Shared types and constants for the range table search block.
// No dependencies; every other file of the block but irts_ram imports this package.
package irts_pkg;

	localparam int unsigned IDX_W = 12;
	localparam int unsigned ADDR_W = 32;
	localparam int unsigned OFS_W = 24;
	localparam int unsigned TABLE_DEPTH_DEF = 4096;
	localparam int unsigned CFG_IDX_W = 1;

	// Request command codes.
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_ENTRY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_ENTRY = 1'b1;

	typedef struct packed {
		logic              command;
		logic [IDX_W-1:0]  entry_index;
		logic [ADDR_W-1:0] entry_start_address;
		logic [OFS_W-1:0]  entry_record_offset;
		logic [ADDR_W-1:0] lookup_address;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0] found_index;
		logic [OFS_W-1:0] record_offset;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;     // capture bounds and address of a lookup
		logic write;    // store a table entry
		logic probe;    // first read of a search
		logic step;     // halve the span and read the next probe
		logic resolve;  // choose between the last two entries
		logic emit;     // move the result into the output register
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic degenerate;  // upper bound not above lower bound
		logic wide;        // more than two entries remain
		logic out_busy;    // output register holds an untaken result
	} dp_stat_t;

endpackage

FILE: sv/irts_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module irts_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/irts_ctrl.sv
// Sequencing state machine for the range table search block.
// Depends on irts_pkg for the command and status structs.
module irts_ctrl import irts_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  logic     req_command,
	output logic     req_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_PROBE = 5'b00010,
		S_STEP  = 5'b00100,
		S_FINAL = 5'b01000,
		S_FETCH = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign req_ready = (state_q == S_IDLE);
	assign accept = req_valid && req_ready;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req_command == CMD_LOOKUP) begin
						cmd.load = 1'b1;
						state_d = S_PROBE;
					end else begin
						cmd.write = 1'b1;
					end
				end
			end
			S_PROBE: begin
				cmd.probe = 1'b1;
				if (stat.degenerate) begin
					state_d = S_FETCH;
				end else if (stat.wide) begin
					state_d = S_STEP;
				end else begin
					state_d = S_FINAL;
				end
			end
			S_STEP: begin
				cmd.step = 1'b1;
				if (!stat.wide) begin
					state_d = S_FINAL;
				end
			end
			S_FINAL: begin
				cmd.resolve = 1'b1;
				state_d = S_FETCH;
			end
			S_FETCH: begin
				// Wait here until the previous result has been taken.
				if (!stat.out_busy) begin
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: sv/irts_dp.sv
// Datapath of the range table search block: bounds, table RAM and result register.
// Depends on irts_pkg and instantiates irts_ram.
module irts_dp import irts_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [IDX_W-1:0]     cfg_data,
	input  req_t                 req,
	input  dp_cmd_t              cmd,
	output dp_stat_t             stat,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output rsp_t                 rsp
);

	localparam int unsigned RAM_AW = $clog2(TABLE_DEPTH);
	localparam int unsigned ENTRY_W = ADDR_W + OFS_W;

	logic [IDX_W-1:0]   first_q, last_q;
	logic [IDX_W-1:0]   lo_q, hi_q, idx_q;
	logic [ADDR_W-1:0]  addr_q;
	logic               oob_q;
	logic [IDX_W-1:0]   cur_lo, cur_hi, span, mid_cur, rd_idx;
	logic [ADDR_W-1:0]  rd_start;
	logic [OFS_W-1:0]   rd_ofs;
	logic [ENTRY_W-1:0] ram_rdata;
	logic               below, degenerate, wide, rd_en, wr_en;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	function automatic logic in_table(input logic [IDX_W-1:0] idx);
		return 33'(idx) < 33'(TABLE_DEPTH);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			last_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_FIRST_ENTRY: first_q <= cfg_data;
				REG_LAST_ENTRY:  last_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Entries past the end of the table read as zero.
	assign rd_start = oob_q ? '0 : ram_rdata[ENTRY_W-1 -: ADDR_W];
	assign rd_ofs = oob_q ? '0 : ram_rdata[OFS_W-1:0];
	assign below = addr_q < rd_start;

	always_comb begin
		cur_lo = lo_q;
		cur_hi = hi_q;
		// During a step the read data belongs to the midpoint held in idx_q.
		if (cmd.step) begin
			if (below) begin
				cur_hi = idx_q;
			end else begin
				cur_lo = idx_q;
			end
		end
		degenerate = cur_hi <= cur_lo;
		span = cur_hi - cur_lo;
		wide = !degenerate && (span > IDX_W'(1));
		mid_cur = cur_lo + (span >> 1);
		if (cmd.resolve) begin
			rd_idx = below ? lo_q : hi_q;
		end else if (degenerate) begin
			rd_idx = cur_lo;
		end else if (wide) begin
			rd_idx = mid_cur;
		end else begin
			rd_idx = cur_hi;
		end
	end

	assign rd_en = cmd.probe || cmd.step || cmd.resolve;
	assign wr_en = cmd.write && in_table(req.entry_index);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lo_q <= first_q;
			hi_q <= last_q;
			addr_q <= req.lookup_address;
		end else if (cmd.probe || cmd.step) begin
			lo_q <= cur_lo;
			hi_q <= cur_hi;
		end
		if (rd_en) begin
			idx_q <= rd_idx;
			oob_q <= !in_table(rd_idx);
		end
		if (cmd.emit) begin
			rsp_q.found_index <= idx_q;
			rsp_q.record_offset <= rd_ofs;
		end
	end

	irts_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (wr_en),
		.waddr(RAM_AW'(req.entry_index)),
		.wdata({req.entry_start_address, req.entry_record_offset}),
		.re   (rd_en),
		.raddr(RAM_AW'(rd_idx)),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign stat.degenerate = degenerate;
	assign stat.wide = wide;
	assign stat.out_busy = rsp_valid_q && !rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

FILE: sv/ip_range_table_search.sv
// Range table search: a table of entries sorted by start address, each with a
// record offset, searched by binary halving between the first_entry and
// last_entry registers. A write request stores one entry. A lookup request is
// loaded, probed, narrowed by one halving step per table read while more than
// two entries remain, resolved between the last two entries unless the window
// is degenerate, and then has its offset fetched; the table RAM gives one
// registered read per step. Requests are taken one at a time; a finished result
// waits in an output register while the next request is accepted. The table is
// not cleared at reset and must be written before use.
// Depends on irts_pkg; instantiates irts_ctrl and irts_dp.
module ip_range_table_search import irts_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [IDX_W-1:0]     cfg_data,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output rsp_t                 rsp
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	irts_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_command(req.command),
		.req_ready  (req_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	irts_dp #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req      (req),
		.cmd      (cmd),
		.stat     (stat),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

endmodule

FILE: sv/irts_checker.sv
// Port-level checks for the range table search block, bound to the top level.
// Depends on irts_pkg for the request and response types.
module irts_checker import irts_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	// A response that is not taken holds its value.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed or dropped while stalled");

	// A lookup occupies the block, so no request is taken in the next cycle.
	a_lookup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.command == CMD_LOOKUP |=> !req_ready)
		else $error("request taken straight after a lookup");

	// A table write completes at once and leaves the block ready.
	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.command == CMD_WRITE |=> req_ready)
		else $error("block not ready after a table write");

	// A new response only appears at the end of a lookup, never from idle.
	a_rsp_from_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("response appeared without a lookup in progress");

endmodule

bind ip_range_table_search irts_checker u_irts_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);

FILE: tb/ip_range_table_search_test.sv
`timescale 1ns / 100ps
// Testbench for ip_range_table_search: drives write and lookup requests under random
// idling, predicts each lookup result in step with the table contents, and checks them.
// Depends on irts_pkg and the ip_range_table_search block.
module ip_range_table_search_test;
	import irts_pkg::*;

	localparam int unsigned DEPTH = TABLE_DEPTH_DEF;
	// Sorted entries written from index 0 up; all but the top-index windows lie in them.
	localparam int unsigned FILL_SPAN = 1024;
	// Wait after the last result in settle; writes give no result to wait for.
	localparam int SETTLE_CYCLES = 24;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [IDX_W-1:0]     cfg_data = '0;
	logic                 req_valid = 1'b0;
	logic                 req_ready;
	req_t                 req = '0;
	logic                 rsp_valid;
	logic                 rsp_ready = 1'b0;
	rsp_t                 rsp;

	// Shadow copy of the table and the search window.
	logic [ADDR_W-1:0] entry_starts [DEPTH];
	logic [OFS_W-1:0]  entry_offsets [DEPTH];
	logic [IDX_W-1:0]  window_first = '0;
	logic [IDX_W-1:0]  window_last = '0;

	rsp_t lookup_answers [$];
	int   mismatch_count = 0;
	bit   no_idle = 1'b0;

	always #10 clk = ~clk;

	ip_range_table_search uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	task automatic report_mismatch(input string what, input logic [31:0] expected,
			input logic [31:0] actual);
		$display("mismatch at %0t: %s, expected %0h, got %0h", $realtime, what, expected,
			actual);
		mismatch_count++;
	endtask

	// Binary search over the shadow table, narrowing while more than two entries remain.
	function automatic rsp_t search_table(input logic [ADDR_W-1:0] addr);
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		rsp_t answer;
		lo = 32'(window_first);
		hi = 32'(window_last);
		if (hi > lo) begin
			while (hi - lo > 1) begin
				mid = lo + (hi - lo) / 2;
				if (addr < entry_starts[mid])
					hi = mid;
				else
					lo = mid;
			end
			if (addr >= entry_starts[hi])
				lo = hi;
		end
		answer.found_index = lo[IDX_W-1:0];
		answer.record_offset = entry_offsets[lo];
		return answer;
	endfunction

	// Holds the request until it is taken; valid is left high for a back-to-back request.
	task automatic send_request(input req_t item);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic write_entry(input int unsigned idx, input logic [ADDR_W-1:0] start,
			input logic [OFS_W-1:0] offset);
		req_t item;
		item.command = CMD_WRITE;
		item.entry_index = idx[IDX_W-1:0];
		item.entry_start_address = start;
		item.entry_record_offset = offset;
		item.lookup_address = $urandom();
		send_request(item);
		entry_starts[idx] = start;
		entry_offsets[idx] = offset;
	endtask

	task automatic lookup(input logic [ADDR_W-1:0] addr);
		req_t item;
		item.command = CMD_LOOKUP;
		item.entry_index = IDX_W'($urandom());
		item.entry_start_address = $urandom();
		item.entry_record_offset = OFS_W'($urandom());
		item.lookup_address = addr;
		send_request(item);
		lookup_answers.push_back(search_table(addr));
	endtask

	// Lets every outstanding lookup finish and any write drain before the window changes.
	task automatic settle();
		req_valid <= 1'b0;
		while (lookup_answers.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_window(input int unsigned lo_idx, input int unsigned hi_idx);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_FIRST_ENTRY;
		cfg_data <= lo_idx[IDX_W-1:0];
		@(posedge clk);
		cfg_index <= REG_LAST_ENTRY;
		cfg_data <= hi_idx[IDX_W-1:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		window_first = lo_idx[IDX_W-1:0];
		window_last = hi_idx[IDX_W-1:0];
	endtask

	// Mostly addresses at or next to a start inside the window, some fully random.
	// Without a proper window only the first entry is searched, so only it is used.
	function automatic logic [ADDR_W-1:0] pick_address();
		int unsigned j;
		if (window_last > window_first)
			j = $urandom_range(32'(window_last), 32'(window_first));
		else
			j = 32'(window_first);
		case ($urandom_range(0, 4))
			0: return $urandom();
			1: return entry_starts[j] - 1;
			2: return entry_starts[j];
			default: return entry_starts[j] + $urandom_range(0, 255);
		endcase
	endfunction

	task automatic test_directed_lookups();
		for (int i = 0; i < 8; i++) begin
			if (i == 0)
				write_entry(i, '0, '0);
			else if (i == 7)
				write_entry(i, '1, OFS_W'($urandom()));
			else
				write_entry(i, i * 32'h100, (i == 1) ? '1 : OFS_W'($urandom()));
		end
		// After reset the window is the single entry 0.
		lookup(32'h50);
		lookup('1);
		settle();
		set_window(1, 7);
		lookup(32'h10);
		lookup(32'h100);
		lookup(32'h2ff);
		lookup(32'h350);
		lookup('0);
		lookup('1);
		settle();
		// Last index below the first: the first entry is returned.
		set_window(6, 2);
		lookup(32'h250);
		lookup('1);
		settle();
	endtask

	task automatic test_full_table();
		logic [ADDR_W-1:0] start;
		start = '0;
		for (int i = 0; i < FILL_SPAN; i++) begin
			if (i == FILL_SPAN - 1)
				start = '1;
			else if (i > 0)
				start = start + $urandom_range(0, 1048000);
			write_entry(i, start, OFS_W'($urandom()));
		end
		// The top index of the table is written on its own for the edge windows.
		write_entry(DEPTH - 1, '1, OFS_W'($urandom()));
		settle();
		set_window(0, FILL_SPAN - 1);
		repeat (24) lookup(pick_address());
		settle();
		set_window(DEPTH - 1, 0);
		repeat (3) lookup(pick_address());
		settle();
		set_window(DEPTH - 1, DEPTH - 1);
		repeat (3) lookup(pick_address());
		settle();
	endtask

	task automatic test_random_windows();
		int unsigned lo_idx;
		int unsigned hi_idx;
		int unsigned idx;
		logic [ADDR_W-1:0] start;
		for (int phase = 0; phase < 15; phase++) begin
			case ($urandom_range(0, 7))
				0: begin
					lo_idx = $urandom_range(1, FILL_SPAN - 1);
					hi_idx = $urandom_range(0, lo_idx - 1);
				end
				1: begin
					lo_idx = $urandom_range(0, FILL_SPAN - 1);
					hi_idx = lo_idx;
				end
				2: begin
					lo_idx = $urandom_range(0, 63);
					hi_idx = $urandom_range(FILL_SPAN - 64, FILL_SPAN - 1);
				end
				default: begin
					lo_idx = $urandom_range(0, FILL_SPAN - 64);
					hi_idx = lo_idx + $urandom_range(1, 40);
				end
			endcase
			set_window(lo_idx, hi_idx);
			no_idle = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < 40; n++) begin
				if ($urandom_range(0, 6) != 0) begin
					lookup(pick_address());
				end else begin
					if ($urandom_range(0, 3) == 0)
						idx = $urandom_range(0, DEPTH - 1);
					else
						idx = (lo_idx < hi_idx) ? $urandom_range(hi_idx, lo_idx) : lo_idx;
					// Keep the table sorted where the neighbours allow it.
					if (idx > 0 && idx < DEPTH - 1
							&& entry_starts[idx - 1] <= entry_starts[idx + 1])
						start = entry_starts[idx - 1]
							+ $urandom_range(0, entry_starts[idx + 1] - entry_starts[idx - 1]);
					else
						start = $urandom();
					write_entry(idx, start, OFS_W'($urandom()));
				end
			end
			settle();
		end
		no_idle = 1'b0;
	endtask

	initial begin : rsp_checker
		int stall;
		rsp_t expected;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			if (lookup_answers.size() == 0) begin
				report_mismatch("result with no lookup pending", '0, 32'(rsp.found_index));
			end else begin
				expected = lookup_answers.pop_front();
				if (rsp.found_index !== expected.found_index)
					report_mismatch("found_index", 32'(expected.found_index),
						32'(rsp.found_index));
				if (rsp.record_offset !== expected.record_offset)
					report_mismatch("record_offset", 32'(expected.record_offset),
						32'(rsp.record_offset));
			end
		end
	end

	initial begin : watchdog
		#15_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin : main
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_lookups();
		test_full_table();
		test_random_windows();
		settle();
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: sim.f
sv/irts_pkg.sv
sv/irts_ram.sv
sv/irts_ctrl.sv
sv/irts_dp.sv
sv/ip_range_table_search.sv
sv/irts_checker.sv
tb/ip_range_table_search_test.sv
